[hw/rtl/mbde_pkg.sv]
// ----------------------------------------------------------------------------
// mbde_pkg
// shared types and constants for the median box distance estimator
// ----------------------------------------------------------------------------
package mbde_pkg;

    // field widths
    localparam int FIELD_W    = 10;
    localparam int EXACT_D_W  = 15;
    localparam int FAR_D_W    = 15;
    localparam int SCALE_W    = 16;
    localparam int DIST_W     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // divider
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = 4;

    // datapath lanes
    localparam int LANES   = 3;
    localparam int LANE_X  = 0;
    localparam int LANE_Y  = 1;
    localparam int LANE_WD = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXACT_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXACT_DISTANCE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_DISTANCE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_SCALE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_OFFSET = 3'd5;

    // register reset values
    localparam logic [FIELD_W-1:0]   RST_EXACT_WIDTH     = 10'd40;
    localparam logic [EXACT_D_W-1:0] RST_EXACT_DISTANCE  = 15'd520;
    localparam logic [FIELD_W-1:0]   RST_WIDTH_LIMIT     = 10'd350;
    localparam logic [FAR_D_W-1:0]   RST_FAR_DISTANCE    = 15'd50;
    localparam logic [SCALE_W-1:0]   RST_DISTANCE_SCALE  = 16'd21189;
    localparam logic [FIELD_W-1:0]   RST_DISTANCE_OFFSET = 10'd20;

    // distance code for a zero median width
    localparam logic [DIST_W-1:0] DIST_NONE = {DIST_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic push;
        logic scan;
        logic eval;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

endpackage

[hw/rtl/mbde_ctrl.sv]
// ----------------------------------------------------------------------------
// mbde_ctrl
// sequencer: rank scan over the windows, divider steps, output handoff
// ----------------------------------------------------------------------------
module mbde_ctrl
    import mbde_pkg::*;
#(
    parameter int WINDOW = 7,
    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output t_dp_cmd       o_cmd,
    output logic [IW-1:0] o_cand_idx
);

    t_state               r_state, n_state;
    logic [IW-1:0]        r_i, r_j;
    logic [DIV_CNT_W-1:0] r_div;
    logic                 r_out_valid;
    logic                 i_last, j_last, div_last, out_free;

    assign i_last   = (r_i == IW'(WINDOW - 1));
    assign j_last   = (r_j == IW'(WINDOW - 1));
    assign div_last = (r_div == DIV_CNT_W'(DIV_STEPS - 1));
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_SCAN;
            S_SCAN: if (i_last && j_last) n_state = S_PREP;
            S_PREP: n_state = S_DIV;
            S_DIV:  if (div_last) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.push = i_valid;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                o_cmd.eval = j_last;
            end
            S_PREP: o_cmd.div_init = 1'b1;
            S_DIV:  o_cmd.div_step = 1'b1;
            S_OUT:  o_cmd.out_load = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_div       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.push) begin
                r_i <= '0;
                r_j <= '0;
            end else if (o_cmd.scan) begin
                if (j_last) begin
                    r_j <= '0;
                    r_i <= i_last ? '0 : r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            if (o_cmd.div_init) begin
                r_div <= '0;
            end else if (o_cmd.div_step) begin
                r_div <= r_div + 1'b1;
            end
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_cand_idx = r_i;

endmodule

[hw/rtl/mbde_datapath.sv]
// ----------------------------------------------------------------------------
// mbde_datapath
// windows, rank-count median, restoring divider, distance select
// ----------------------------------------------------------------------------
module mbde_datapath
    import mbde_pkg::*;
#(
    parameter int WINDOW = 7,
    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1,
    localparam int CW = $clog2(WINDOW + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [IW-1:0]         i_cand_idx,
    input  logic                  i_cfg_write,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_found,
    input  logic [FIELD_W-1:0]    i_box_x,
    input  logic [FIELD_W-1:0]    i_box_y,
    input  logic [FIELD_W-1:0]    i_box_width,
    output logic [FIELD_W-1:0]    o_median_x,
    output logic [FIELD_W-1:0]    o_median_y,
    output logic [FIELD_W-1:0]    o_median_width,
    output logic [DIST_W-1:0]     o_distance
);

    localparam logic [CW-1:0] RANK = CW'(WINDOW >> 1);

    logic [FIELD_W-1:0]   r_exact_width, r_width_limit, r_distance_offset;
    logic [EXACT_D_W-1:0] r_exact_distance;
    logic [FAR_D_W-1:0]   r_far_distance;
    logic [SCALE_W-1:0]   r_distance_scale;

    logic [FIELD_W-1:0] r_win  [LANES][WINDOW];
    logic [FIELD_W-1:0] n_win  [LANES][WINDOW];
    logic [FIELD_W-1:0] r_scan [LANES][WINDOW];
    logic [FIELD_W-1:0] lane_in [LANES];
    logic [FIELD_W-1:0] cand    [LANES];
    logic [CW-1:0]      r_lt [LANES], r_le [LANES];
    logic [CW-1:0]      n_lt [LANES], n_le [LANES];
    logic [FIELD_W-1:0] r_med [LANES];

    logic [FIELD_W-1:0] r_rem;
    logic [SCALE_W-1:0] r_quot;
    logic [FIELD_W:0]   trial;
    logic               trial_ge;

    logic [FIELD_W-1:0] r_out_x, r_out_y, r_out_w;
    logic [DIST_W-1:0]  r_out_dist, n_dist;
    logic [FIELD_W-1:0] m;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exact_width     <= RST_EXACT_WIDTH;
            r_exact_distance  <= RST_EXACT_DISTANCE;
            r_width_limit     <= RST_WIDTH_LIMIT;
            r_far_distance    <= RST_FAR_DISTANCE;
            r_distance_scale  <= RST_DISTANCE_SCALE;
            r_distance_offset <= RST_DISTANCE_OFFSET;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_EXACT_WIDTH:     r_exact_width     <= i_cfg_data[FIELD_W-1:0];
                CFG_EXACT_DISTANCE:  r_exact_distance  <= i_cfg_data[EXACT_D_W-1:0];
                CFG_WIDTH_LIMIT:     r_width_limit     <= i_cfg_data[FIELD_W-1:0];
                CFG_FAR_DISTANCE:    r_far_distance    <= i_cfg_data[FAR_D_W-1:0];
                CFG_DISTANCE_SCALE:  r_distance_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_DISTANCE_OFFSET: r_distance_offset <= i_cfg_data[FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    // no detection pushes zeros
    assign lane_in[LANE_X]  = i_found ? i_box_x     : '0;
    assign lane_in[LANE_Y]  = i_found ? i_box_y     : '0;
    assign lane_in[LANE_WD] = i_found ? i_box_width : '0;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            for (int k = 0; k < WINDOW - 1; k++) begin
                n_win[l][k] = r_win[l][k+1];
            end
            n_win[l][WINDOW-1] = lane_in[l];
            cand[l] = r_win[l][i_cand_idx];
            n_lt[l] = r_lt[l] + CW'(r_scan[l][0] <  cand[l]);
            n_le[l] = r_le[l] + CW'(r_scan[l][0] <= cand[l]);
        end
    end

    // windows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LANES; l++) begin
                for (int k = 0; k < WINDOW; k++) begin
                    r_win[l][k] <= '0;
                end
            end
        end else if (i_cmd.push) begin
            r_win <= n_win;
        end
    end

    // rotating scan copy and rank counters
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_cmd.push) begin
                r_scan[l] <= n_win[l];
                r_lt[l]   <= '0;
                r_le[l]   <= '0;
            end else if (i_cmd.scan) begin
                for (int k = 0; k < WINDOW - 1; k++) begin
                    r_scan[l][k] <= r_scan[l][k+1];
                end
                r_scan[l][WINDOW-1] <= r_scan[l][0];
                if (i_cmd.eval) begin
                    // candidate sits at the wanted rank of the sorted window
                    if ((n_lt[l] <= RANK) && (n_le[l] > RANK)) begin
                        r_med[l] <= cand[l];
                    end
                    r_lt[l] <= '0;
                    r_le[l] <= '0;
                end else begin
                    r_lt[l] <= n_lt[l];
                    r_le[l] <= n_le[l];
                end
            end
        end
    end

    // restoring divider, one quotient bit per step
    assign m        = r_med[LANE_WD];
    assign trial    = {r_rem, r_quot[SCALE_W-1]};
    assign trial_ge = (trial >= {1'b0, m});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem  <= '0;
            r_quot <= r_distance_scale;
        end else if (i_cmd.div_step) begin
            r_rem  <= trial_ge ? FIELD_W'(trial - {1'b0, m}) : trial[FIELD_W-1:0];
            r_quot <= {r_quot[SCALE_W-2:0], trial_ge};
        end
    end

    always_comb begin
        if (m == '0) begin
            n_dist = DIST_NONE;
        end else if (m == r_exact_width) begin
            n_dist = DIST_W'(r_exact_distance);
        end else if (m < r_width_limit) begin
            // negative result clamps to zero
            if (r_quot < SCALE_W'(r_distance_offset)) begin
                n_dist = '0;
            end else begin
                n_dist = DIST_W'(r_quot - SCALE_W'(r_distance_offset));
            end
        end else begin
            n_dist = DIST_W'(r_far_distance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_x    <= r_med[LANE_X];
            r_out_y    <= r_med[LANE_Y];
            r_out_w    <= r_med[LANE_WD];
            r_out_dist <= n_dist;
        end
    end

    assign o_median_x     = r_out_x;
    assign o_median_y     = r_out_y;
    assign o_median_width = r_out_w;
    assign o_distance     = r_out_dist;

endmodule

[hw/rtl/median_box_distance_estimator.sv]
// ----------------------------------------------------------------------------
// median_box_distance_estimator
// per-frame median of box x, y and width over a sliding window, plus a
// distance estimate from the median width
// ----------------------------------------------------------------------------
// sequence per request: rank scan (one compare per lane a cycle), divider
//   preparation, the 16-step divider, then the output register
// one request at a time: a new request is taken only after the previous
//   result is loaded into the output register
// reset: synchronous active low, windows cleared to zero, registers to defaults
module median_box_distance_estimator
    import mbde_pkg::*;
#(
    parameter int WINDOW = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_found,
    input  logic [FIELD_W-1:0]    i_box_x,
    input  logic [FIELD_W-1:0]    i_box_y,
    input  logic [FIELD_W-1:0]    i_box_width,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [FIELD_W-1:0]    o_median_x,
    output logic [FIELD_W-1:0]    o_median_y,
    output logic [FIELD_W-1:0]    o_median_width,
    output logic signed [DIST_W-1:0] o_distance,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    t_dp_cmd          cmd;
    logic [IW-1:0]    cand_idx;
    logic [DIST_W-1:0] distance;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer: one request at a time, result waits in the output register
    mbde_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_cmd      (cmd),
        .o_cand_idx (cand_idx)
    );

    // windows, median by rank counting, divider and output register
    mbde_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cand_idx     (cand_idx),
        .i_cfg_write    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_found        (i_found),
        .i_box_x        (i_box_x),
        .i_box_y        (i_box_y),
        .i_box_width    (i_box_width),
        .o_median_x     (o_median_x),
        .o_median_y     (o_median_y),
        .o_median_width (o_median_width),
        .o_distance     (distance)
    );

    // two's complement, all ones when the median width is zero
    assign o_distance = signed'(distance);

endmodule

[sim/mbde_checker.sv]
// ----------------------------------------------------------------------------
// mbde_checker
// watches the request, result and register channels of the median box
// distance estimator, predicts each frame's medians and distance, and
// compares every accepted result with the oldest prediction
// ----------------------------------------------------------------------------
module mbde_checker
    import mbde_pkg::*;
#(
    parameter int WINDOW = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_req_valid,
    input  logic                     i_req_stall,
    input  logic                     i_found,
    input  logic [FIELD_W-1:0]       i_box_x,
    input  logic [FIELD_W-1:0]       i_box_y,
    input  logic [FIELD_W-1:0]       i_box_width,
    // result channel
    input  logic                     i_res_valid,
    input  logic                     i_res_stall,
    input  logic [FIELD_W-1:0]       i_median_x,
    input  logic [FIELD_W-1:0]       i_median_y,
    input  logic [FIELD_W-1:0]       i_median_width,
    input  logic signed [DIST_W-1:0] i_distance,
    // register write channel
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    // status to the testbench top
    output int                       o_fail_count,
    output int                       o_pending
);

    // predictions waiting for their result, kept as a ring
    localparam int EXP_DEPTH = 16;

    typedef logic [WINDOW-1:0][FIELD_W-1:0] t_history;

    typedef struct packed {
        logic [FIELD_W-1:0] median_x;
        logic [FIELD_W-1:0] median_y;
        logic [FIELD_W-1:0] median_width;
        logic [DIST_W-1:0]  distance;
    } t_estimate;

    t_history             x_hist;
    t_history             y_hist;
    t_history             w_hist;
    logic [FIELD_W-1:0]   exact_width;
    logic [EXACT_D_W-1:0] exact_distance;
    logic [FIELD_W-1:0]   width_limit;
    logic [FAR_D_W-1:0]   far_distance;
    logic [SCALE_W-1:0]   distance_scale;
    logic [FIELD_W-1:0]   distance_offset;
    t_estimate            expected_estimates [EXP_DEPTH];
    int                   exp_rd = 0;
    int                   exp_wr = 0;
    int                   exp_count = 0;
    t_estimate            oldest;
    t_estimate            fresh;
    int                   failures = 0;

    assign o_fail_count = failures;

    // newest value in, oldest value out
    function automatic t_history shift_in(t_history h, logic [FIELD_W-1:0] v);
        for (int i = WINDOW - 1; i > 0; i--) begin
            h[i] = h[i - 1];
        end
        h[0] = v;
        return h;
    endfunction

    // element WINDOW>>1 of the ascending sort, upper median for even sizes
    function automatic logic [FIELD_W-1:0] window_median(t_history h);
        logic [FIELD_W-1:0] tmp;
        for (int i = 0; i < WINDOW - 1; i++) begin
            for (int j = 0; j < WINDOW - 1 - i; j++) begin
                if (h[j] > h[j + 1]) begin
                    tmp      = h[j];
                    h[j]     = h[j + 1];
                    h[j + 1] = tmp;
                end
            end
        end
        return h[WINDOW >> 1];
    endfunction

    function automatic logic [DIST_W-1:0] range_from_width(logic [FIELD_W-1:0] m);
        logic [SCALE_W-1:0] quotient;
        if (m == '0) begin
            return DIST_NONE;
        end
        if (m == exact_width) begin
            return DIST_W'(exact_distance);
        end
        if (m < width_limit) begin
            quotient = distance_scale / SCALE_W'(m);
            // quotient below the offset clamps to zero
            if (quotient < SCALE_W'(distance_offset)) begin
                return '0;
            end
            return DIST_W'(quotient - SCALE_W'(distance_offset));
        end
        return DIST_W'(far_distance);
    endfunction

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            x_hist          = '0;
            y_hist          = '0;
            w_hist          = '0;
            exact_width     = RST_EXACT_WIDTH;
            exact_distance  = RST_EXACT_DISTANCE;
            width_limit     = RST_WIDTH_LIMIT;
            far_distance    = RST_FAR_DISTANCE;
            distance_scale  = RST_DISTANCE_SCALE;
            distance_offset = RST_DISTANCE_OFFSET;
            exp_rd          = 0;
            exp_wr          = 0;
            exp_count       = 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_EXACT_WIDTH:     exact_width     = i_cfg_data[FIELD_W-1:0];
                    CFG_EXACT_DISTANCE:  exact_distance  = i_cfg_data[EXACT_D_W-1:0];
                    CFG_WIDTH_LIMIT:     width_limit     = i_cfg_data[FIELD_W-1:0];
                    CFG_FAR_DISTANCE:    far_distance    = i_cfg_data[FAR_D_W-1:0];
                    CFG_DISTANCE_SCALE:  distance_scale  = i_cfg_data[SCALE_W-1:0];
                    CFG_DISTANCE_OFFSET: distance_offset = i_cfg_data[FIELD_W-1:0];
                    default: ;
                endcase
            end

            if (i_res_valid && !i_res_stall) begin
                if (exp_count == 0) begin
                    $error("result with no request waiting: x %0d y %0d width %0d dist %0d",
                           i_median_x, i_median_y, i_median_width, i_distance);
                    failures++;
                end else begin
                    oldest    = expected_estimates[exp_rd];
                    exp_rd    = (exp_rd + 1) % EXP_DEPTH;
                    exp_count = exp_count - 1;
                    check_field("median_x", oldest.median_x, i_median_x);
                    check_field("median_y", oldest.median_y, i_median_y);
                    check_field("median_width", oldest.median_width, i_median_width);
                    check_field("distance", $signed(oldest.distance), i_distance);
                end
            end

            if (i_req_valid && !i_req_stall) begin
                // a frame without a detection pushes zeros
                x_hist = shift_in(x_hist, i_found ? i_box_x : '0);
                y_hist = shift_in(y_hist, i_found ? i_box_y : '0);
                w_hist = shift_in(w_hist, i_found ? i_box_width : '0);
                fresh.median_x     = window_median(x_hist);
                fresh.median_y     = window_median(y_hist);
                fresh.median_width = window_median(w_hist);
                fresh.distance     = range_from_width(fresh.median_width);
                if (exp_count == EXP_DEPTH) begin
                    $error("too many requests without a result: %0d waiting", exp_count);
                    failures++;
                end else begin
                    expected_estimates[exp_wr] = fresh;
                    exp_wr    = (exp_wr + 1) % EXP_DEPTH;
                    exp_count = exp_count + 1;
                end
            end

            o_pending <= exp_count;
        end
    end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// regression for the median box distance estimator: directed frames at the
// reset settings, then tracked-object and noise frames under several
// register settings and idle/stall patterns, checked by mbde_checker
// ----------------------------------------------------------------------------
module tb_top;
    import mbde_pkg::*;

    localparam int WINDOW            = 7;
    // about 1300 frames with random gaps and stalls, each one a full rank scan
    // and divide, fit well inside this limit
    localparam int CYCLE_LIMIT       = 1_000_000;
    localparam int SETTLE_CYCLES     = WINDOW * WINDOW + 19;
    localparam int FRAMES_PER_PHASE  = 160;
    localparam int PHASES            = 8;

    // indexes past the register file, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    logic                     req_found;
    logic [FIELD_W-1:0]       req_box_x;
    logic [FIELD_W-1:0]       req_box_y;
    logic [FIELD_W-1:0]       req_box_width;
    logic                     res_valid;
    logic                     res_stall = 1'b0;
    logic [FIELD_W-1:0]       res_median_x;
    logic [FIELD_W-1:0]       res_median_y;
    logic [FIELD_W-1:0]       res_median_width;
    logic signed [DIST_W-1:0] res_distance;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    int                       fail_count;
    int                       pending;
    int                       send_idle_pct = 0;
    int                       stall_pct = 0;
    int                       frames_sent = 0;
    int                       settings_used = 0;
    int                       cycles;
    // current register values, used only to aim widths at interesting medians
    logic [FIELD_W-1:0]       cur_exact_width;
    logic [FIELD_W-1:0]       cur_width_limit;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    median_box_distance_estimator #(
        .WINDOW (WINDOW)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (req_valid),
        .o_stall        (req_stall),
        .i_found        (req_found),
        .i_box_x        (req_box_x),
        .i_box_y        (req_box_y),
        .i_box_width    (req_box_width),
        .o_valid        (res_valid),
        .i_stall        (res_stall),
        .o_median_x     (res_median_x),
        .o_median_y     (res_median_y),
        .o_median_width (res_median_width),
        .o_distance     (res_distance),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    mbde_checker #(
        .WINDOW (WINDOW)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req_valid    (req_valid),
        .i_req_stall    (req_stall),
        .i_found        (req_found),
        .i_box_x        (req_box_x),
        .i_box_y        (req_box_y),
        .i_box_width    (req_box_width),
        .i_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .i_median_x     (res_median_x),
        .i_median_y     (res_median_y),
        .i_median_width (res_median_width),
        .i_distance     (res_distance),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // result side back-pressure, redrawn every cycle
    always @(posedge clk) begin
        res_stall <= ($urandom_range(99) < stall_pct);
    end

    // small wobble around a tracked value, wraps at the field width
    function automatic logic [FIELD_W-1:0] wobble();
        return FIELD_W'(int'($urandom_range(4)) - 2);
    endfunction

    // present one frame request and hold it until it is taken
    task automatic send_frame(input logic f, input logic [FIELD_W-1:0] x,
                              input logic [FIELD_W-1:0] y, input logic [FIELD_W-1:0] w);
        // sender gaps land between requests, never on a held one
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid     <= 1'b1;
        req_found     <= f;
        req_box_x     <= x;
        req_box_y     <= y;
        req_box_width <= w;
        do @(posedge clk); while (req_stall);
        frames_sent++;
    endtask

    // stop sending and wait until every predicted result has been taken
    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // one register write, cfg_valid stays up for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_EXACT_WIDTH) begin
            cur_exact_width = data[FIELD_W-1:0];
        end
        if (idx == CFG_WIDTH_LIMIT) begin
            cur_width_limit = data[FIELD_W-1:0];
        end
    endtask

    // full register setting; spare indexes get junk first, it must not land
    task automatic apply_setting(input logic [CFG_DATA_W-1:0] ew, input logic [CFG_DATA_W-1:0] ed,
                                 input logic [CFG_DATA_W-1:0] wl, input logic [CFG_DATA_W-1:0] fd,
                                 input logic [CFG_DATA_W-1:0] sc, input logic [CFG_DATA_W-1:0] off);
        write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
        write_reg(CFG_EXACT_WIDTH, ew);
        write_reg(CFG_EXACT_DISTANCE, ed);
        write_reg(CFG_WIDTH_LIMIT, wl);
        write_reg(CFG_FAR_DISTANCE, fd);
        write_reg(CFG_DISTANCE_SCALE, sc);
        write_reg(CFG_DISTANCE_OFFSET, off);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // mostly runs of a steady object with random content, some noise frames
    task automatic run_traffic(input int count);
        int                 done;
        int                 run_len;
        logic [FIELD_W-1:0] bx;
        logic [FIELD_W-1:0] by;
        logic [FIELD_W-1:0] bw;
        done = 0;
        while (done < count) begin
            if ($urandom_range(9) == 0) begin
                // noise frame, any field pattern
                send_frame(1'($urandom_range(1)), FIELD_W'($urandom), FIELD_W'($urandom),
                           FIELD_W'($urandom));
                done++;
            end else begin
                run_len = $urandom_range(3, 12);
                bx      = FIELD_W'($urandom);
                by      = FIELD_W'($urandom);
                // aim the width at the exact match, the reciprocal range,
                // the limit boundary or anywhere
                case ($urandom_range(3))
                    0:       bw = cur_exact_width;
                    1:       bw = FIELD_W'($urandom_range(1, 64));
                    2:       bw = cur_width_limit + wobble();
                    default: bw = FIELD_W'($urandom);
                endcase
                for (int i = 0; i < run_len && done < count; i++) begin
                    // occasional full drain before the next request
                    if ($urandom_range(99) == 0) begin
                        wait_drained();
                    end
                    // dropouts break the run with a no-detection frame
                    send_frame($urandom_range(15) != 0, bx + wobble(), by + wobble(),
                               ($urandom_range(2) == 0) ? bw + wobble() : bw);
                    done++;
                end
            end
        end
    endtask

    // watchdog
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("median_box_distance_estimator regression: fail");
        $finish;
    end

    initial begin
        rst_n           <= 1'b0;
        req_valid       <= 1'b0;
        req_found       <= 1'b0;
        req_box_x       <= '0;
        req_box_y       <= '0;
        req_box_width   <= '0;
        cfg_valid       <= 1'b0;
        cfg_index       <= CFG_EXACT_WIDTH;
        cfg_data        <= '0;
        cur_exact_width = RST_EXACT_WIDTH;
        cur_width_limit = RST_WIDTH_LIMIT;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed frames at reset settings, no idling
        // all-ones box into empty windows, median stays zero so distance is -1
        send_frame(1'b1, 10'h3FF, 10'h3FF, 10'h3FF);
        // no detection, box fields must be ignored
        send_frame(1'b0, 10'h3FF, 10'h3FF, 10'h3FF);
        // hold off until the block has answered everything
        wait_drained();
        // median lands on the exact width
        repeat (4) send_frame(1'b1, 10'h2AA, 10'h155, RST_EXACT_WIDTH);
        // smallest width, biggest reciprocal quotient
        repeat (4) send_frame(1'b1, 10'h155, 10'h2AA, 10'd1);
        // just under and right at the width limit
        repeat (4) send_frame(1'b1, 10'd0, 10'h3FF, RST_WIDTH_LIMIT - 10'd1);
        repeat (4) send_frame(1'b1, 10'h3FF, 10'd0, RST_WIDTH_LIMIT);
        repeat (2) send_frame(1'b1, 10'd0, 10'd0, 10'h3FF);
        // detections lost, windows fill with zeros again
        repeat (4) send_frame(1'b0, 10'h155, 10'h2AA, 10'h3FF);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                // phase 0 keeps the reset settings
                1: apply_setting('1, '1, '1, '1, '1, '1);
                // exact width zero: a zero median must still report -1
                2: apply_setting('0, '0, '0, '0, '0, '0);
                // reset values, with junk above the width of every register narrower than 16 bits
                3: apply_setting(16'hFC28, 16'h8208, 16'hFD5E, 16'h8032, 16'd21189, 16'hFC14);
                // widest reciprocal range, no offset
                4: apply_setting(16'd1000, 16'd32767, 16'd1023, 16'd12345, 16'hFFFF, 16'd0);
                5, 6, 7: apply_setting(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                       CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                       CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
                default: ;
            endcase
            // idle patterns cycle: none, sender gaps, result stalls, both
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 53; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 53; end
                default: begin send_idle_pct = 38; stall_pct = 38; end
            endcase
            run_traffic(FRAMES_PER_PHASE);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d frames under %0d written register settings plus reset values,",
                 frames_sent, settings_used);
        $display("with sender gaps and result stalls off, alone and together");
        if (fail_count == 0 && pending == 0) begin
            $display("median_box_distance_estimator regression: pass");
        end else begin
            $display("median_box_distance_estimator regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/mbde_pkg.sv
hw/rtl/mbde_ctrl.sv
hw/rtl/mbde_datapath.sv
hw/rtl/median_box_distance_estimator.sv
sim/mbde_checker.sv
sim/tb_top.sv
